@@ rtl/dqb_pkg.sv @@
`timescale 1ns / 1ps
// Package for the DNS query builder: shared types, constants and byte tables.
// No dependencies; imported by the controller, the datapath and the top level.
package dqb_pkg;

    localparam logic [7:0] C_DOT_CODE    = 8'h2E;
    localparam logic [7:0] C_ZERO_BYTE   = 8'h00;
    localparam logic [7:0] C_ONE_BYTE    = 8'h01;
    localparam logic [15:0] C_MSG_ID_RST = 16'hDB42;
    localparam logic [7:0] C_QTYPE_RST   = 8'h01;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_MESSAGE_ID = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_TYPE = 2'd1;

    localparam int IDX_W = 4;
    localparam logic [IDX_W-1:0] C_HDR_LAST  = 4'd11;
    localparam logic [IDX_W-1:0] C_TAIL_LAST = 4'd4;

    typedef enum logic [1:0] {
        SRC_HDR,
        SRC_LEN,
        SRC_LBL,
        SRC_TAIL
    } t_src;

    typedef struct packed {
        logic             accept;
        logic             emit;
        t_src             sel;
        logic [IDX_W-1:0] idx;
        logic             lbl_start;
        logic             lbl_step;
        logic             lbl_clear;
        logic             pkt_end;
        logic             eor;
        logic             eop;
    } t_dqb_cmd;

    typedef struct packed {
        logic hdr_sent;
        logic label_empty;
        logic lbl_last;
        logic slot_free;
        logic in_dot;
    } t_dqb_sts;

    // Header: id high, id low, flags 0x0100, qdcount 1, three zero counts.
    function automatic logic [7:0] hdr_byte(input logic [IDX_W-1:0] idx,
                                            input logic [15:0] msg_id);
        logic [7:0] b;
        case (idx)
            4'd0:    b = msg_id[15:8];
            4'd1:    b = msg_id[7:0];
            4'd2:    b = C_ONE_BYTE;
            4'd5:    b = C_ONE_BYTE;
            default: b = C_ZERO_BYTE;
        endcase
        return b;
    endfunction

    // Tail: root label, type 0x00 then query type, class 0x0001.
    function automatic logic [7:0] tail_byte(input logic [IDX_W-1:0] idx,
                                             input logic [7:0] qtype);
        logic [7:0] b;
        case (idx)
            4'd2:    b = qtype;
            4'd4:    b = C_ONE_BYTE;
            default: b = C_ZERO_BYTE;
        endcase
        return b;
    endfunction

endpackage

@@ rtl/dqb_char_if.sv @@
`timescale 1ns / 1ps
// Input channel of the DNS query builder: one hostname character a transaction.
// Standalone interface; no dependencies.
interface dqb_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink (input valid, input char_code, input last, output ready);
endinterface

@@ rtl/dqb_byte_if.sv @@
`timescale 1ns / 1ps
// Output channel of the DNS query builder: one packet byte a transaction.
// Standalone interface; no dependencies.
interface dqb_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       end_of_run;
    logic       end_of_packet;
    logic       label_too_long;

    modport source (output valid, output out_byte, output end_of_run,
                    output end_of_packet, output label_too_long, input ready);
    modport sink (input valid, input out_byte, input end_of_run,
                  input end_of_packet, input label_too_long, output ready);
endinterface

@@ rtl/dqb_ctrl.sv @@
`timescale 1ns / 1ps
// Controller of the DNS query builder: sequences header, label and tail bytes.
// Depends on dqb_pkg; drives the datapath through t_dqb_cmd.
module dqb_ctrl
    import dqb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_last,
    input  t_dqb_sts i_sts,
    output logic     o_in_ready,
    output t_dqb_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HDR,
        S_LEN,
        S_LBL,
        S_TAIL
    } t_state;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_cnt, n_cnt;
    logic             r_flush, n_flush;
    logic             r_last, n_last;

    logic accept;
    logic emit;
    logic flush_now;

    assign accept = i_in_valid && (r_state == S_IDLE);
    assign emit   = i_sts.slot_free && (r_state != S_IDLE);
    // A dot closes only a non-empty label; a final non-dot always leaves one.
    assign flush_now = i_sts.in_dot ? !i_sts.label_empty : i_in_last;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_flush = r_flush;
        n_last  = r_last;
        o_cmd   = '0;
        o_cmd.accept = accept;
        o_cmd.emit   = emit;
        o_cmd.idx    = r_cnt;
        o_cmd.sel    = SRC_HDR;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_flush = flush_now;
                    n_last  = i_in_last;
                    n_cnt   = '0;
                    if (!i_sts.hdr_sent) begin
                        n_state = S_HDR;
                    end else if (flush_now) begin
                        n_state = S_LEN;
                    end else if (i_in_last) begin
                        n_state = S_TAIL;
                    end
                end
            end
            S_HDR: begin
                o_cmd.sel = SRC_HDR;
                if (emit) begin
                    if (r_cnt == C_HDR_LAST) begin
                        n_cnt = '0;
                        if (r_flush) begin
                            n_state = S_LEN;
                        end else if (r_last) begin
                            n_state = S_TAIL;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            S_LEN: begin
                o_cmd.sel       = SRC_LEN;
                o_cmd.lbl_start = 1'b1;
                if (emit) begin
                    n_state = S_LBL;
                end
            end
            S_LBL: begin
                o_cmd.sel = SRC_LBL;
                if (emit) begin
                    if (i_sts.lbl_last) begin
                        o_cmd.lbl_clear = 1'b1;
                        n_cnt           = '0;
                        n_state         = r_last ? S_TAIL : S_IDLE;
                    end else begin
                        o_cmd.lbl_step = 1'b1;
                    end
                end
            end
            S_TAIL: begin
                o_cmd.sel = SRC_TAIL;
                if (emit) begin
                    if (r_cnt == C_TAIL_LAST) begin
                        o_cmd.pkt_end = 1'b1;
                        o_cmd.eop     = 1'b1;
                        n_state       = S_IDLE;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        o_cmd.eor = emit && (n_state == S_IDLE);
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_flush <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_flush <= n_flush;
            r_last  <= n_last;
        end
    end

endmodule

@@ rtl/dqb_datapath.sv @@
`timescale 1ns / 1ps
// Datapath of the DNS query builder: label memory, counters, settings and the
// output register. Depends on dqb_pkg; commanded by dqb_ctrl.
module dqb_datapath
    import dqb_pkg::*;
#(
    parameter int MAX_LABEL = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dqb_cmd              i_cmd,
    output t_dqb_sts              o_sts,
    input  logic [7:0]            i_char_code,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [7:0]            o_out_byte,
    output logic                  o_end_of_run,
    output logic                  o_end_of_packet,
    output logic                  o_label_too_long
);

    localparam int CW = $clog2(MAX_LABEL + 1);
    localparam int AW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
    localparam logic [CW-1:0] C_MAX = CW'(MAX_LABEL);

    logic [7:0]    r_mem [MAX_LABEL];
    logic [7:0]    r_rd_data;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic          r_hdr_sent;
    logic          r_overflow;
    logic [15:0]   r_msg_id;
    logic [7:0]    r_qtype;
    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic          r_eor;
    logic          r_eop;
    logic          r_ltl;

    logic          in_dot;
    logic          store_char;
    logic [CW-1:0] idx_next;
    logic [AW-1:0] rd_addr;
    logic [7:0]    byte_sel;

    assign in_dot     = (i_char_code == C_DOT_CODE);
    assign store_char = i_cmd.accept && !in_dot && (r_count < C_MAX);
    assign idx_next   = r_idx + 1'b1;

    // The read runs one byte ahead so that registered data is ready on emit.
    always_comb begin
        if (i_cmd.lbl_start) begin
            rd_addr = '0;
        end else if (i_cmd.lbl_step && (idx_next < C_MAX)) begin
            rd_addr = idx_next[AW-1:0];
        end else begin
            rd_addr = r_idx[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_char) begin
            r_mem[r_count[AW-1:0]] <= i_char_code;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_comb begin
        case (i_cmd.sel)
            SRC_HDR:  byte_sel = hdr_byte(i_cmd.idx, r_msg_id);
            SRC_LEN:  byte_sel = 8'(r_count);
            SRC_LBL:  byte_sel = r_rd_data;
            SRC_TAIL: byte_sel = tail_byte(i_cmd.idx, r_qtype);
            default:  byte_sel = C_ZERO_BYTE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_idx      <= '0;
            r_hdr_sent <= 1'b0;
            r_overflow <= 1'b0;
            r_msg_id   <= C_MSG_ID_RST;
            r_qtype    <= C_QTYPE_RST;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MESSAGE_ID: r_msg_id <= i_cfg_data;
                    CFG_QUERY_TYPE: r_qtype  <= i_cfg_data[7:0];
                    default:        ;
                endcase
            end
            if (i_cmd.accept) begin
                r_hdr_sent <= 1'b1;
                if (store_char) begin
                    r_count <= r_count + 1'b1;
                end else if (!in_dot) begin
                    r_overflow <= 1'b1;
                end
            end
            if (i_cmd.emit && i_cmd.lbl_start) begin
                r_idx <= '0;
            end else if (i_cmd.lbl_step) begin
                r_idx <= idx_next;
            end
            if (i_cmd.lbl_clear) begin
                r_count <= '0;
            end
            if (i_cmd.pkt_end) begin
                r_count    <= '0;
                r_hdr_sent <= 1'b0;
                r_overflow <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_byte <= byte_sel;
            r_eor      <= i_cmd.eor;
            r_eop      <= i_cmd.eop;
            r_ltl      <= r_overflow;
        end
    end

    assign o_sts.hdr_sent    = r_hdr_sent;
    assign o_sts.label_empty = (r_count == '0);
    assign o_sts.lbl_last    = (r_idx == (r_count - 1'b1));
    assign o_sts.slot_free   = !r_out_valid || i_out_ready;
    assign o_sts.in_dot      = in_dot;

    assign o_out_valid      = r_out_valid;
    assign o_out_byte       = r_out_byte;
    assign o_end_of_run     = r_eor;
    assign o_end_of_packet  = r_eop;
    assign o_label_too_long = r_ltl;

endmodule

@@ rtl/dns_query_builder.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Transaction carries
// i_char    in   char_code (8), last (1)
// o_pkt     out  out_byte (8), end_of_run, end_of_packet, label_too_long
// i_cfg_*   in   register index (2), write data (16); always ready
//
// An item is taken while the sequencer is idle; its bytes then leave one per
// cycle while o_pkt accepts them: 12 for a header, 1 + n for a label of n
// characters, 5 for the tail. The next item is taken only once every byte of the last one has been issued.
// The byte sequencer and the single label memory read port set this pace.
// Reset is synchronous; the label memory needs no clearing pass. A stall on
// o_pkt holds the sequencer; the last byte of an item may wait while the next
// item is taken.
module dns_query_builder
    import dqb_pkg::*;
#(
    parameter int MAX_LABEL = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    dqb_char_if.sink              i_char,
    dqb_byte_if.source            o_pkt,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dqb_cmd cmd;
    t_dqb_sts sts;

    assign o_cfg_ready = 1'b1;

    dqb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_char.valid),
        .i_in_last  (i_char.last),
        .i_sts      (sts),
        .o_in_ready (i_char.ready),
        .o_cmd      (cmd)
    );

    dqb_datapath #(
        .MAX_LABEL (MAX_LABEL)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_char_code      (i_char.char_code),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_out_ready      (o_pkt.ready),
        .o_out_valid      (o_pkt.valid),
        .o_out_byte       (o_pkt.out_byte),
        .o_end_of_run     (o_pkt.end_of_run),
        .o_end_of_packet  (o_pkt.end_of_packet),
        .o_label_too_long (o_pkt.label_too_long)
    );

endmodule

@@ rtl/dqb_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the DNS query builder, attached by bind.
// Depends only on the top level's ports.
module dqb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_eor,
    input logic       i_out_eop,
    input logic       i_out_ltl
);

    logic r_after_eop;

    // Set once a packet has closed, cleared by the next output transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_after_eop <= 1'b0;
        end else if (i_out_valid && i_out_ready) begin
            r_after_eop <= i_out_eop;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte)
            && $stable(i_out_eop))
        else $error("output transaction changed while stalled");

    a_eop_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_eop |-> i_out_eor)
        else $error("end of packet without end of run");

    a_fresh_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_after_eop && i_out_valid |-> !i_out_ltl)
        else $error("truncation flag carried into a new packet");

    a_accept_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |-> !i_out_valid || i_out_eor)
        else $error("input taken while an item still had bytes pending");

endmodule

bind dns_query_builder dqb_checker u_dqb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_char.valid),
    .i_in_ready  (i_char.ready),
    .i_out_valid (o_pkt.valid),
    .i_out_ready (o_pkt.ready),
    .i_out_byte  (o_pkt.out_byte),
    .i_out_eor   (o_pkt.end_of_run),
    .i_out_eop   (o_pkt.end_of_packet),
    .i_out_ltl   (o_pkt.label_too_long)
);

@@ dv/tb_dns_query_builder.sv @@
`timescale 1ns / 1ps
// Testbench for dns_query_builder: sends hostnames one character at a time and
// checks every packet byte against an in-bench model. Needs dqb_pkg and both channel interfaces.
module tb_dns_query_builder
    import dqb_pkg::*;
;

    localparam int MAX_LABEL    = 32;
    localparam int RANDOM_ITEMS = 250;
    localparam int SETTLE_CYCLES = 40;
    localparam int QUIET_LIMIT  = 1000;
    localparam int HDR_BYTES    = 12;

    // Indexes past the two registers; the block must ignore writes to them.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam logic [7:0] C_LOWER_A = 8'h61;
    localparam logic [7:0] C_LOWER_Z = 8'h7A;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_run;
        logic       end_of_packet;
        logic       label_too_long;
    } t_pkt_byte;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    dqb_char_if char_ch ();
    dqb_byte_if pkt_ch ();

    dns_query_builder #(
        .MAX_LABEL(MAX_LABEL)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_char     (char_ch),
        .o_pkt      (pkt_ch),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Model state of the query builder.
    logic [7:0]  label_buf [MAX_LABEL];
    logic [5:0]  label_len;
    logic        hdr_done;
    logic        trunc_seen;
    logic [15:0] msg_id;
    logic [7:0]  qtype;

    t_pkt_byte expected_bytes[$];
    int        err_count = 0;
    int        items_sent;
    bit        tx_burst;
    bit        rx_burst = 1'b0;
    int        rx_wait;
    int        rx_hold;
    int        quiet_cycles = 0;

    function automatic t_pkt_byte plain_byte(input logic [7:0] b);
        t_pkt_byte r;
        r = '{out_byte: b, end_of_run: 1'b0, end_of_packet: 1'b0, label_too_long: 1'b0};
        return r;
    endfunction

    function automatic void push_label(ref t_pkt_byte run[$]);
        int i;
        if (label_len != 0) begin
            run.push_back(plain_byte({2'b00, label_len}));
            for (i = 0; i < label_len; i++)
                run.push_back(plain_byte(label_buf[i]));
            label_len = '0;
        end
    endfunction

    // Works out the packet bytes that one accepted character causes.
    function automatic void build_bytes(input logic [7:0] c, input logic is_last);
        t_pkt_byte run[$];
        logic [7:0] hdr [HDR_BYTES];
        int k;
        hdr = '{msg_id[15:8], msg_id[7:0], C_ONE_BYTE, C_ZERO_BYTE, C_ZERO_BYTE,
                C_ONE_BYTE, C_ZERO_BYTE, C_ZERO_BYTE, C_ZERO_BYTE, C_ZERO_BYTE,
                C_ZERO_BYTE, C_ZERO_BYTE};
        if (!hdr_done) begin
            for (k = 0; k < HDR_BYTES; k++)
                run.push_back(plain_byte(hdr[k]));
            hdr_done = 1'b1;
        end
        if (c == C_DOT_CODE) begin
            push_label(run);
        end else if (label_len < MAX_LABEL) begin
            label_buf[label_len] = c;
            label_len = label_len + 1'b1;
        end else begin
            trunc_seen = 1'b1;
        end
        if (is_last) begin
            push_label(run);
            run.push_back(plain_byte(C_ZERO_BYTE));
            run.push_back(plain_byte(C_ZERO_BYTE));
            run.push_back(plain_byte(qtype));
            run.push_back(plain_byte(C_ZERO_BYTE));
            run.push_back(plain_byte(C_ONE_BYTE));
        end
        for (k = 0; k < run.size(); k++)
            run[k].label_too_long = trunc_seen;
        if (run.size() > 0) begin
            run[run.size() - 1].end_of_run = 1'b1;
            run[run.size() - 1].end_of_packet = is_last;
        end
        foreach (run[k])
            expected_bytes.push_back(run[k]);
        if (is_last) begin
            label_len = '0;
            hdr_done = 1'b0;
            trunc_seen = 1'b0;
        end
    endfunction

    // Valid stays high on return so that a back-to-back character needs no toggle.
    task automatic send_char(input logic [7:0] c, input logic is_last);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            char_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        char_ch.valid     <= 1'b1;
        char_ch.char_code <= c;
        char_ch.last      <= is_last;
        do @(posedge i_clk); while (!char_ch.ready);
        build_bytes(c, is_last);
        items_sent++;
    endtask

    task automatic send_name(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    task automatic wait_drain();
        char_ch.valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!cfg_ready);
        if (idx == CFG_MESSAGE_ID)
            msg_id = data;
        else if (idx == CFG_QUERY_TYPE)
            qtype = data[7:0];
    endtask

    // Called only between packets, after wait_drain.
    task automatic program_regs(input logic [15:0] id, input logic [7:0] qt);
        if ($urandom_range(0, 2) == 0)
            write_reg($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3,
                      16'($urandom_range(0, 16'hFFFF)));
        write_reg(CFG_QUERY_TYPE, {8'($urandom_range(0, 8'hFF)), qt});
        write_reg(CFG_MESSAGE_ID, id);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_values();
        send_name("ab.c");
        send_char("x", 1'b1);
        wait_drain();
    endtask

    task automatic test_empty_labels();
        send_name(".a..b.");
        send_char(C_DOT_CODE, 1'b1);
        wait_drain();
    endtask

    task automatic test_byte_extremes();
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h2D, 1'b0);
        send_char(8'h2F, 1'b0);
        send_char(C_DOT_CODE, 1'b0);
        send_char(8'h80, 1'b0);
        send_char(8'h7F, 1'b1);
        wait_drain();
    endtask

    task automatic test_registers();
        program_regs(16'h0000, 8'h00);
        send_name("p.q");
        wait_drain();
        program_regs(16'hFFFF, 8'hFF);
        send_name("r");
        wait_drain();
        write_reg(CFG_SPARE_2, 16'hFFFF);
        write_reg(CFG_SPARE_3, 16'h0000);
        cfg_valid <= 1'b0;
        send_name("s.t");
        wait_drain();
    endtask

    // A label of exactly the limit, then one past it by several characters.
    task automatic test_overlong_label();
        int i;
        tx_burst = 1'b1;
        for (i = 0; i < MAX_LABEL; i++)
            send_char(8'($urandom_range(C_LOWER_A, C_LOWER_Z)), 1'b0);
        send_char(C_DOT_CODE, 1'b0);
        tx_burst = 1'b0;
        for (i = 0; i < MAX_LABEL + 8; i++)
            send_char(8'($urandom_range(C_LOWER_A, C_LOWER_Z)), 1'b0);
        send_char(C_DOT_CODE, 1'b1);
        // The truncation flag must not leak into the next packet.
        send_name("z.y");
        wait_drain();
    endtask

    task automatic send_random_name();
        logic [7:0] name[$];
        int n_lbl;
        int len;
        int i;
        int j;
        int r;
        tx_burst = ($urandom_range(0, 3) == 0);
        n_lbl = $urandom_range(1, 4);
        if ($urandom_range(0, 9) == 0)
            name.push_back(C_DOT_CODE);
        for (i = 0; i < n_lbl; i++) begin
            r = $urandom_range(0, 19);
            if (r == 0)
                len = 0;
            else if (r == 1)
                len = $urandom_range(MAX_LABEL - 2, MAX_LABEL + 8);
            else
                len = $urandom_range(1, 10);
            for (j = 0; j < len; j++) begin
                if ($urandom_range(0, 7) == 0)
                    name.push_back(8'($urandom_range(0, 255)));
                else
                    name.push_back(8'($urandom_range(C_LOWER_A, C_LOWER_Z)));
            end
            if (i != n_lbl - 1) begin
                name.push_back(C_DOT_CODE);
                if ($urandom_range(0, 9) == 0)
                    name.push_back(C_DOT_CODE);
            end
        end
        if (name.size() == 0 || $urandom_range(0, 6) == 0)
            name.push_back(C_DOT_CODE);
        for (i = 0; i < name.size(); i++)
            send_char(name[i], i == name.size() - 1);
    endtask

    task automatic test_random_names();
        int pkts;
        int r;
        logic [15:0] id;
        logic [7:0] qt;
        pkts = 0;
        while (items_sent < RANDOM_ITEMS) begin
            send_random_name();
            pkts++;
            if (pkts % 4 == 0) begin
                wait_drain();
                r = $urandom_range(0, 3);
                id = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF :
                     16'($urandom_range(0, 16'hFFFF));
                r = $urandom_range(0, 3);
                qt = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(0, 8'hFF));
                program_regs(id, qt);
            end
        end
        wait_drain();
    endtask

    // Byte checker and receive-side stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pkt_ch.ready <= 1'b1;
            rx_hold      <= 0;
        end else if (pkt_ch.valid && pkt_ch.ready) begin
            if (expected_bytes.size() == 0) begin
                err_count++;
                $display("%0t: unexpected byte %h (eor %b eop %b too_long %b)", $time,
                         pkt_ch.out_byte, pkt_ch.end_of_run, pkt_ch.end_of_packet,
                         pkt_ch.label_too_long);
            end else if (pkt_ch.out_byte !== expected_bytes[0].out_byte ||
                         pkt_ch.end_of_run !== expected_bytes[0].end_of_run ||
                         pkt_ch.end_of_packet !== expected_bytes[0].end_of_packet ||
                         pkt_ch.label_too_long !== expected_bytes[0].label_too_long) begin
                err_count++;
                $display("%0t: byte/eor/eop/too_long expected %h/%b/%b/%b, got %h/%b/%b/%b",
                         $time, expected_bytes[0].out_byte, expected_bytes[0].end_of_run,
                         expected_bytes[0].end_of_packet, expected_bytes[0].label_too_long,
                         pkt_ch.out_byte, pkt_ch.end_of_run, pkt_ch.end_of_packet,
                         pkt_ch.label_too_long);
            end
            if (expected_bytes.size() != 0) begin
                if (expected_bytes[0].end_of_packet)
                    rx_burst = ($urandom_range(0, 3) == 0);
                void'(expected_bytes.pop_front());
            end
            rx_wait = rx_burst ? 0 : $urandom_range(0, 7);
            if (rx_wait != 0) begin
                pkt_ch.ready <= 1'b0;
                rx_hold <= rx_wait;
            end
        end else if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
            if (rx_hold == 1)
                pkt_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((char_ch.valid && char_ch.ready) || (pkt_ch.valid && pkt_ch.ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        char_ch.valid     = 1'b0;
        char_ch.char_code = '0;
        char_ch.last      = 1'b0;
        cfg_valid         = 1'b0;
        cfg_index         = CFG_MESSAGE_ID;
        cfg_data          = '0;
        label_len         = '0;
        hdr_done          = 1'b0;
        trunc_seen        = 1'b0;
        msg_id            = C_MSG_ID_RST;
        qtype             = C_QTYPE_RST;
        items_sent        = 0;
        tx_burst          = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_empty_labels();
        test_byte_extremes();
        test_registers();
        test_overlong_label();
        test_random_names();

        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
